FILE: src/pwrft_pkg.sv
// ----------------------------------------------------------------------------
// pwrft_pkg
// shared types and constants of the row freshness tracker
// ----------------------------------------------------------------------------
package pwrft_pkg;

  localparam int ROW_W      = 20;  // global row index
  localparam int WORKER_W   = 4;   // worker id
  localparam int KIND_W     = 3;   // request kind
  localparam int ROW_IDX_W  = 6;   // local row index carried in a command
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int CMD_DEPTH  = 2;   // depth of the front to back queue

  // request kinds on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_ROW   = 3'd0,
    KIND_ADD_ALL   = 3'd1,
    KIND_GET_ROW   = 3'd2,
    KIND_GET_STALE = 3'd3,
    KIND_GET_ALL   = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_OFFSET     = 2'd0,
    CFG_ROWS_IN_USE    = 2'd1,
    CFG_WORKERS_IN_USE = 2'd2
  } cfg_idx_t;

  // commands handed from the front to the back
  typedef enum logic [2:0] {
    OP_ADD_ROW   = 3'd0,
    OP_ADD_ALL   = 3'd1,
    OP_GET_ROW   = 3'd2,
    OP_GET_STALE = 3'd3,
    OP_GET_ALL   = 3'd4,
    OP_ERROR     = 3'd5
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [WORKER_W-1:0]  worker;
    logic [ROW_W-1:0]     row;    // global row, or reply row for errors
    logic [ROW_IDX_W-1:0] idx;    // local row index
    logic                 last;   // last key, or end flag for errors
    logic                 touch;  // error result belongs to a get request
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             eor;
    logic             no_row;
    logic             range_err;
  } res_t;

endpackage

FILE: src/pwrft_ram.sv
// ----------------------------------------------------------------------------
// pwrft_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pwrft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pwrft_front.sv
// ----------------------------------------------------------------------------
// pwrft_front
// accepts request items, checks ranges and turns them into commands
// ----------------------------------------------------------------------------
module pwrft_front #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_WORKERS = 16
) (
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [23:0]                          in_tdata,   // worker, row
  input  logic                                 in_tlast,
  input  logic [pwrft_pkg::KIND_W-1:0]         in_tuser,   // kind
  input  logic [pwrft_pkg::ROW_W-1:0]          row_offset,
  input  logic [$clog2(MAX_ROWS+1)-1:0]        nrows,
  input  logic [$clog2(MAX_WORKERS+1)-1:0]     nwork,
  input  logic                                 q_full,
  output logic                                 q_push,
  output pwrft_pkg::cmd_t                      q_cmd
);

  logic [pwrft_pkg::WORKER_W-1:0] worker;
  logic [pwrft_pkg::ROW_W-1:0]    row;
  logic [pwrft_pkg::ROW_W-1:0]    local_row;
  logic                           worker_ok;
  logic                           row_ok;
  logic                           known;

  assign worker    = in_tdata[3:0];
  assign row       = in_tdata[23:4];
  assign local_row = row - row_offset;
  assign worker_ok = 8'(worker) < 8'(nwork);
  assign row_ok    = local_row < pwrft_pkg::ROW_W'(nrows);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && known;

  always_comb begin
    known        = 1'b1;
    q_cmd.op     = pwrft_pkg::OP_ERROR;
    q_cmd.worker = worker;
    q_cmd.row    = row;
    q_cmd.idx    = local_row[pwrft_pkg::ROW_IDX_W-1:0];
    q_cmd.last   = 1'b1;
    q_cmd.touch  = 1'b0;
    case (pwrft_pkg::kind_t'(in_tuser))
      pwrft_pkg::KIND_ADD_ROW: begin
        if (worker_ok && row_ok) begin
          q_cmd.op = pwrft_pkg::OP_ADD_ROW;
        end
      end
      pwrft_pkg::KIND_ADD_ALL: begin
        if (worker_ok) begin
          q_cmd.op = pwrft_pkg::OP_ADD_ALL;
        end else begin
          q_cmd.row = '0;
        end
      end
      pwrft_pkg::KIND_GET_ROW: begin
        q_cmd.last  = in_tlast;
        q_cmd.touch = 1'b1;
        if (worker_ok && row_ok) begin
          q_cmd.op = pwrft_pkg::OP_GET_ROW;
        end
      end
      pwrft_pkg::KIND_GET_STALE: begin
        q_cmd.touch = 1'b1;
        if (worker_ok) begin
          q_cmd.op = pwrft_pkg::OP_GET_STALE;
        end else begin
          q_cmd.row = '0;
        end
      end
      pwrft_pkg::KIND_GET_ALL: begin
        q_cmd.op = pwrft_pkg::OP_GET_ALL;
      end
      default: begin
        known = 1'b0;  // unknown kinds are dropped
      end
    endcase
  end

endmodule

FILE: src/pwrft_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pwrft_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module pwrft_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pwrft_pkg::cmd_t push_cmd,
  input  logic            pop,
  output pwrft_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = $clog2(pwrft_pkg::CMD_DEPTH);
  localparam int CW = $clog2(pwrft_pkg::CMD_DEPTH + 1);

  pwrft_pkg::cmd_t mem_r [pwrft_pkg::CMD_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign full  = count_r == CW'(pwrft_pkg::CMD_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/pwrft_back.sv
// ----------------------------------------------------------------------------
// pwrft_back
// carries out commands on the mark store and drives the result register
// ----------------------------------------------------------------------------
module pwrft_back #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_WORKERS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pwrft_pkg::ROW_W-1:0]      row_offset,
  input  logic [$clog2(MAX_ROWS+1)-1:0]    nrows,
  input  logic [$clog2(MAX_WORKERS+1)-1:0] nwork,
  input  logic                             q_empty,
  input  pwrft_pkg::cmd_t                  q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pwrft_pkg::res_t                  out_res
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WR   = 5'b00010,  // read data present, modify and write
    S_FIN  = 5'b00100,  // closing result of a stale walk
    S_ALL  = 5'b01000,  // unconditional row list
    S_ERR  = 5'b10000   // single error result
  } state_t;

  state_t                    state_r, state_nxt;
  pwrft_pkg::cmd_t           cmd_r, cmd_nxt;
  logic [ROW_AW-1:0]         r_r, r_nxt;
  logic                      em_r, em_nxt;        // emitted_any
  logic                      have_r, have_nxt;    // pending stale row held
  logic [pwrft_pkg::ROW_W-1:0] pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  pwrft_pkg::res_t           out_res_r, out_res_nxt;
  logic [MAX_ROWS-1:0]       valid_r;
  logic                      rd_valid_r;

  logic                      ram_we, ram_re;
  logic [ROW_AW-1:0]         ram_waddr, ram_raddr;
  logic [MAX_WORKERS-1:0]    ram_wdata, ram_rdata, marks;
  logic [MAX_WORKERS-1:0]    self_v, others_v;
  logic                      out_free, emit, stale, r_last;
  pwrft_pkg::res_t           emit_res;
  logic [pwrft_pkg::ROW_W-1:0] walk_row;

  pwrft_ram #(
    .WIDTH (MAX_WORKERS),
    .DEPTH (MAX_ROWS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rows never written since reset read as all stale
  assign marks    = rd_valid_r ? ram_rdata : '0;
  assign stale    = (marks & self_v) == '0;
  assign out_free = !out_valid_r || out_ready;
  assign r_last   = (ROW_CW'(r_r) + ROW_CW'(1)) == nrows;
  assign walk_row = pwrft_pkg::ROW_W'(row_offset + pwrft_pkg::ROW_W'(r_r));
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    for (int w = 0; w < MAX_WORKERS; w++) begin
      self_v[w]   = int'(cmd_r.worker) == w;
      others_v[w] = (w < int'(nwork)) && !(int'(cmd_r.worker) == w);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    r_nxt     = r_r;
    em_nxt    = em_r;
    have_nxt  = have_r;
    pend_nxt  = pend_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = r_r;
    ram_raddr = r_r;
    ram_wdata = marks;
    emit      = 1'b0;
    emit_res  = '{row: walk_row, eor: 1'b0, no_row: 1'b0, range_err: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          r_nxt   = '0;
          case (q_head.op)
            pwrft_pkg::OP_ADD_ROW, pwrft_pkg::OP_GET_ROW: begin
              ram_re    = 1'b1;
              ram_raddr = q_head.idx[ROW_AW-1:0];
              state_nxt = S_WR;
            end
            pwrft_pkg::OP_ADD_ALL: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = S_WR;
            end
            pwrft_pkg::OP_GET_STALE: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              em_nxt    = 1'b0;
              have_nxt  = 1'b0;
              pend_nxt  = row_offset;
              state_nxt = S_WR;
            end
            pwrft_pkg::OP_GET_ALL: begin
              em_nxt    = 1'b0;
              state_nxt = S_ALL;
            end
            default: begin
              state_nxt = S_ERR;
            end
          endcase
        end
      end

      S_WR: begin
        case (cmd_r.op)
          pwrft_pkg::OP_ADD_ROW: begin
            ram_we    = 1'b1;
            ram_waddr = cmd_r.idx[ROW_AW-1:0];
            ram_wdata = marks & ~others_v;
            state_nxt = S_IDLE;
          end
          pwrft_pkg::OP_ADD_ALL: begin
            ram_we    = 1'b1;
            ram_wdata = marks & ~others_v;
            if (r_last) begin
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = r_r + ROW_AW'(1);
              ram_re    = 1'b1;
              ram_raddr = r_r + ROW_AW'(1);
            end
          end
          pwrft_pkg::OP_GET_ROW: begin
            emit_res.row = cmd_r.row;
            emit_res.eor = cmd_r.last;
            if (stale) begin
              if (out_free) begin
                ram_we    = 1'b1;
                ram_waddr = cmd_r.idx[ROW_AW-1:0];
                ram_wdata = marks | self_v;
                emit      = 1'b1;
                em_nxt    = !cmd_r.last;
                state_nxt = S_IDLE;
              end
            end else if (!cmd_r.last) begin
              state_nxt = S_IDLE;
            end else if (out_free) begin
              // fresh last key: close the request, or send row 0 if empty
              emit            = 1'b1;
              emit_res.row    = em_r ? '0 : row_offset;
              emit_res.eor    = 1'b1;
              emit_res.no_row = em_r;
              em_nxt          = 1'b0;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            // stale walk: one result held back so the last can carry eor
            emit_res.row = pend_r;
            if (!(stale && have_r && !out_free)) begin
              if (stale) begin
                ram_we    = 1'b1;
                ram_wdata = marks | self_v;
                emit      = have_r;
                pend_nxt  = walk_row;
                have_nxt  = 1'b1;
              end
              if (r_last) begin
                state_nxt = S_FIN;
              end else begin
                r_nxt     = r_r + ROW_AW'(1);
                ram_re    = 1'b1;
                ram_raddr = r_r + ROW_AW'(1);
              end
            end
          end
        endcase
      end

      S_FIN: begin
        emit_res.row = pend_r;
        emit_res.eor = 1'b1;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_ALL: begin
        emit_res.eor = r_last;
        if (out_free) begin
          emit = 1'b1;
          if (r_last) begin
            state_nxt = S_IDLE;
          end else begin
            r_nxt = r_r + ROW_AW'(1);
          end
        end
      end

      S_ERR: begin
        emit_res = '{row: cmd_r.row, eor: cmd_r.last, no_row: 1'b1, range_err: 1'b1};
        if (out_free) begin
          emit = 1'b1;
          if (cmd_r.touch) begin
            em_nxt = !cmd_r.last;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      em_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      em_r        <= em_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    r_r       <= r_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
    if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
    end
  end

endmodule

FILE: src/per_worker_row_freshness_tracker.sv
// ----------------------------------------------------------------------------
// per_worker_row_freshness_tracker
// keeps one freshness mark per worker for every locally held row
// ----------------------------------------------------------------------------
// Requests come in one item at a time and are checked and queued by the front
// (a two-entry command queue), so the input keeps moving while the back works
// on the mark store and a result waits in the output register, until the
// queue fills. The back owns a ram with one read and one write port, one word
// per row, MAX_WORKERS bits wide, with one valid flop per row so the store
// reads as all stale straight after reset and needs no clearing pass. Steps
// per item, set by the ram's registered read and single write port: add or
// get of one row reads, then modifies and writes; add all walks the rows at
// one row per cycle; get all stale does too while out_tready lets its results
// go, then sends a closing result; get all unconditional sends one row per
// cycle while out_tready allows; a range error sends one result. Local row is
// global row minus row_offset, modulo 2^20.
// ----------------------------------------------------------------------------
module per_worker_row_freshness_tracker #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_WORKERS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // worker[3:0], row[23:4]
  input  logic                                in_tlast,   // last key of a get-row request
  input  logic [2:0]                          in_tuser,   // kind
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // out_row[19:0], zero pad
  output logic                                out_tlast,  // end of reply
  output logic [1:0]                          out_tuser,  // no_row[0], range_error[1]
  // configuration writes
  input  logic                                cfg_we,
  input  logic [pwrft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwrft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int NW_CW  = $clog2(MAX_WORKERS + 1);

  // configuration registers
  logic [pwrft_pkg::ROW_W-1:0] row_offset_r;
  logic [6:0]                  rows_in_use_r;
  logic [4:0]                  workers_in_use_r;

  // clamped counts used by both halves
  logic [ROW_CW-1:0]           nrows;
  logic [NW_CW-1:0]            nwork;

  // front to back queue
  logic                        q_push, q_pop, q_full, q_empty;
  pwrft_pkg::cmd_t             q_cmd, q_head;
  pwrft_pkg::res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_offset_r     <= '0;
      rows_in_use_r    <= 7'd64;
      workers_in_use_r <= 5'd16;
    end else if (cfg_we) begin
      case (pwrft_pkg::cfg_idx_t'(cfg_index))
        pwrft_pkg::CFG_ROW_OFFSET:     row_offset_r     <= cfg_wdata;
        pwrft_pkg::CFG_ROWS_IN_USE:    rows_in_use_r    <= cfg_wdata[6:0];
        pwrft_pkg::CFG_WORKERS_IN_USE: workers_in_use_r <= cfg_wdata[4:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // counts clamped to 1..MAX
  always_comb begin
    if (rows_in_use_r == '0) begin
      nrows = ROW_CW'(1);
    end else if (int'(rows_in_use_r) > MAX_ROWS) begin
      nrows = ROW_CW'(MAX_ROWS);
    end else begin
      nrows = ROW_CW'(rows_in_use_r);
    end
    if (workers_in_use_r == '0) begin
      nwork = NW_CW'(1);
    end else if (int'(workers_in_use_r) > MAX_WORKERS) begin
      nwork = NW_CW'(MAX_WORKERS);
    end else begin
      nwork = NW_CW'(workers_in_use_r);
    end
  end

  // classify and range check
  pwrft_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .row_offset (row_offset_r),
    .nrows      (nrows),
    .nwork      (nwork),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  pwrft_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // mark store, walks and result register
  pwrft_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_offset (row_offset_r),
    .nrows      (nrows),
    .nwork      (nwork),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'b0000, res.row};
  assign out_tlast = res.eor;
  assign out_tuser = {res.range_err, res.no_row};

endmodule
